[rtl/core/cau_pkg.sv]
`default_nettype none

package cau_pkg;

  // Word format
  localparam int DW = 32;              // component width
  localparam int FB = 16;              // fraction bits
  localparam int PW = 2 * DW;          // full product / divisor width
  localparam int SW = PW + 1;          // sum of two products
  localparam int NW = SW - FB;         // shifted product, add/sub result
  localparam int HW = SW - (DW - FB);  // scaled numerator above the quotient bits
  localparam int NREG = DW + 1;        // divider registers: setup plus one per quotient bit

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Side band that rides along the divider stages
  typedef struct packed {
    op_e                   op;
    logic                  dz;      // divide with zero divisor
    logic                  neg_re;  // sign of real numerator
    logic                  neg_im;
    logic                  pre_re;  // quotient already >= 2^DW
    logic                  pre_im;
    logic signed [NW-1:0]  val_re;  // add/sub/mul result before saturation
    logic signed [NW-1:0]  val_im;
  } ctl_t;

  // One restoring divider lane
  typedef struct packed {
    logic [PW-1:0] rem;
    logic [DW-1:0] num_lo;  // numerator bits still to shift in
    logic [DW-1:0] quo;
  } lane_t;

endpackage

`default_nettype wire

[rtl/core/cau_div_pipe.sv]
`default_nettype none

module cau_div_pipe (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire cau_pkg::ctl_t   ctl_i,
  input  wire logic [cau_pkg::PW-1:0] den_i,
  input  wire cau_pkg::lane_t  re_i,
  input  wire cau_pkg::lane_t  im_i,
  output logic                 valid_o,
  output cau_pkg::ctl_t        ctl_o,
  output cau_pkg::lane_t       re_o,
  output cau_pkg::lane_t       im_o
);
  import cau_pkg::*;

  // one quotient bit per stage
  function automatic lane_t div_step(lane_t l, logic [PW-1:0] d);
    logic [PW:0] r2;
    logic [PW:0] diff;
    lane_t       o;
    r2       = {l.rem, l.num_lo[DW-1]};
    diff     = r2 - {1'b0, d};
    o.num_lo = {l.num_lo[DW-2:0], 1'b0};
    if (r2 >= {1'b0, d}) begin
      o.rem = diff[PW-1:0];
      o.quo = {l.quo[DW-2:0], 1'b1};
    end else begin
      o.rem = r2[PW-1:0];
      o.quo = {l.quo[DW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic          vld_q [NREG];
  ctl_t          ctl_q [NREG];
  logic [PW-1:0] den_q [NREG];
  lane_t         re_q  [NREG];
  lane_t         im_q  [NREG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NREG; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < NREG; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q[0] <= ctl_i;
      den_q[0] <= den_i;
      re_q[0]  <= re_i;
      im_q[0]  <= im_i;
      for (int k = 1; k < NREG; k++) begin
        ctl_q[k] <= ctl_q[k-1];
        den_q[k] <= den_q[k-1];
        re_q[k]  <= div_step(re_q[k-1], den_q[k-1]);
        im_q[k]  <= div_step(im_q[k-1], den_q[k-1]);
      end
    end
  end

  assign valid_o = vld_q[NREG-1];
  assign ctl_o   = ctl_q[NREG-1];
  assign re_o    = re_q[NREG-1];
  assign im_o    = im_q[NREG-1];

endmodule

`default_nettype wire

[rtl/core/complex_arithmetic_unit_top.sv]
// Complex arithmetic unit: one word in, one word out, add, subtract, multiply
// or divide of two signed Q16.16 complex operands. Every operation takes the
// same path, so a word is accepted each cycle unless the pipeline stalls, and
// results leave in order through two product/sum stages, a setup stage, 32
// restoring-division stages giving one quotient bit each and one saturation
// stage. The whole pipeline stalls together when a result waits at the
// output. Products round toward minus infinity, quotients truncate toward
// zero; out-of-range components saturate and raise overflow. A divide by zero
// returns zero with div_by_zero set and overflow clear.
`default_nettype none

module complex_arithmetic_unit_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic signed [cau_pkg::DW-1:0] a_re_i,
  input  wire logic signed [cau_pkg::DW-1:0] a_im_i,
  input  wire logic signed [cau_pkg::DW-1:0] b_re_i,
  input  wire logic signed [cau_pkg::DW-1:0] b_im_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [cau_pkg::DW-1:0]     res_re_o,
  output logic signed [cau_pkg::DW-1:0]     res_im_o,
  output logic                              div_by_zero_o,
  output logic                              overflow_o
);
  import cau_pkg::*;

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  // pipeline advances unless the output word is held
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---- stage 1: products and plain sums ----
  logic                 v1_q;
  op_e                  op1_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_br_q, p_bi_q;
  logic signed [DW:0]   s_re_q, s_im_q;
  op_e                  op_in;

  assign op_in = op_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= op_in;
      p_rr_q <= PW'(a_re_i) * PW'(b_re_i);
      p_ii_q <= PW'(a_im_i) * PW'(b_im_i);
      p_ir_q <= PW'(a_im_i) * PW'(b_re_i);
      p_ri_q <= PW'(b_im_i) * PW'(a_re_i);
      p_br_q <= PW'(b_re_i) * PW'(b_re_i);
      p_bi_q <= PW'(b_im_i) * PW'(b_im_i);
      if (op_in == OP_SUB) begin
        s_re_q <= (DW+1)'(a_re_i) - (DW+1)'(b_re_i);
        s_im_q <= (DW+1)'(a_im_i) - (DW+1)'(b_im_i);
      end else begin
        s_re_q <= (DW+1)'(a_re_i) + (DW+1)'(b_re_i);
        s_im_q <= (DW+1)'(a_im_i) + (DW+1)'(b_im_i);
      end
    end
  end

  // ---- stage 2: cross sums and |B|^2 ----
  logic                 v2_q;
  op_e                  op2_q;
  logic signed [SW-1:0] w_re_q, w_im_q;
  logic [PW-1:0]        den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q <= op1_q;
      den_q <= $unsigned(p_br_q) + $unsigned(p_bi_q);
      case (op1_q)
        OP_MUL: begin
          w_re_q <= SW'(p_rr_q) - SW'(p_ii_q);
          w_im_q <= SW'(p_ir_q) + SW'(p_ri_q);
        end
        OP_DIV: begin
          w_re_q <= SW'(p_rr_q) + SW'(p_ii_q);
          w_im_q <= SW'(p_ir_q) - SW'(p_ri_q);
        end
        default: begin
          w_re_q <= SW'(s_re_q);
          w_im_q <= SW'(s_im_q);
        end
      endcase
    end
  end

  // ---- divider setup: magnitude, scaled numerator, early overflow ----
  ctl_t          ctl_d;
  lane_t         re_d, im_d;
  logic [SW-1:0] mag_re, mag_im;

  assign mag_re = w_re_q[SW-1] ? $unsigned(-w_re_q) : $unsigned(w_re_q);
  assign mag_im = w_im_q[SW-1] ? $unsigned(-w_im_q) : $unsigned(w_im_q);

  always_comb begin
    re_d.rem    = PW'(mag_re[SW-1:DW-FB]);
    re_d.num_lo = {mag_re[DW-FB-1:0], {FB{1'b0}}};
    re_d.quo    = '0;
    im_d.rem    = PW'(mag_im[SW-1:DW-FB]);
    im_d.num_lo = {mag_im[DW-FB-1:0], {FB{1'b0}}};
    im_d.quo    = '0;
    ctl_d.op     = op2_q;
    ctl_d.dz     = (op2_q == OP_DIV) && (den_q == '0);
    ctl_d.neg_re = w_re_q[SW-1];
    ctl_d.neg_im = w_im_q[SW-1];
    ctl_d.pre_re = PW'(mag_re[SW-1:DW-FB]) >= den_q;
    ctl_d.pre_im = PW'(mag_im[SW-1:DW-FB]) >= den_q;
    if (op2_q == OP_MUL) begin
      ctl_d.val_re = NW'(w_re_q >>> FB);
      ctl_d.val_im = NW'(w_im_q >>> FB);
    end else begin
      ctl_d.val_re = NW'(w_re_q);
      ctl_d.val_im = NW'(w_im_q);
    end
  end

  logic  vp;
  ctl_t  ctlp;
  lane_t rep, imp;

  cau_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .ctl_i   (ctl_d),
    .den_i   (den_q),
    .re_i    (re_d),
    .im_i    (im_d),
    .valid_o (vp),
    .ctl_o   (ctlp),
    .re_o    (rep),
    .im_o    (imp)
  );

  // ---- saturation and output register ----
  function automatic logic [DW:0] sat_quo(logic neg, logic pre, logic [DW-1:0] q);
    // returns {overflow, value}
    logic [DW-1:0] lim;
    lim = {1'b1, {(DW-1){1'b0}}};
    if (neg) begin
      if (pre || q > lim) return {1'b1, MINV};
      return {1'b0, DW'(-q)};
    end
    if (pre || q[DW-1]) return {1'b1, MAXV};
    return {1'b0, q};
  endfunction

  function automatic logic [DW:0] sat_val(logic signed [NW-1:0] v);
    if (v > NW'(MAXV)) return {1'b1, MAXV};
    if (v < NW'(MINV)) return {1'b1, MINV};
    return {1'b0, v[DW-1:0]};
  endfunction

  logic [DW:0] f_re, f_im;

  always_comb begin
    if (ctlp.op == OP_DIV) begin
      f_re = sat_quo(ctlp.neg_re, ctlp.pre_re, rep.quo);
      f_im = sat_quo(ctlp.neg_im, ctlp.pre_im, imp.quo);
    end else begin
      f_re = sat_val(ctlp.val_re);
      f_im = sat_val(ctlp.val_im);
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ctlp.dz) begin
        res_re_o      <= '0;
        res_im_o      <= '0;
        div_by_zero_o <= 1'b1;
        overflow_o    <= 1'b0;
      end else begin
        res_re_o      <= f_re[DW-1:0];
        res_im_o      <= f_im[DW-1:0];
        div_by_zero_o <= 1'b0;
        overflow_o    <= f_re[DW] | f_im[DW];
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[verif/tb_complex_arithmetic_unit_top.sv]
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit_top;
  import cau_pkg::*;

  // Q16.16 limits, held wide so that sums and products never wrap
  localparam logic signed [127:0] SAT_HI = 128'sh7fff_ffff;
  localparam logic signed [127:0] SAT_LO = -SAT_HI - 1;
  localparam int FRAC = 16;
  localparam int LATENCY = 36;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               dz;
    logic               ovf;
  } cplx_res_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] req_type_i;
  logic signed [31:0] a_re_i, a_im_i, b_re_i, b_im_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [31:0] res_re_o, res_im_o;
  logic div_by_zero_o, overflow_o;

  cplx_res_t pending_q[$];   // results owed by the block, oldest first
  int        errors;
  longint    cycles;
  bit        steady;         // when set, neither side idles

  complex_arithmetic_unit_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i,
    .a_re_i, .a_im_i, .b_re_i, .b_im_i,
    .out_valid_o, .out_stall_i, .res_re_o, .res_im_o,
    .div_by_zero_o, .overflow_o
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Clamp a wide value to Q16.16; returns {clipped, value}
  function automatic logic [32:0] clamp_q16(input logic signed [127:0] v);
    if (v > SAT_HI) return {1'b1, SAT_HI[31:0]};
    if (v < SAT_LO) return {1'b1, SAT_LO[31:0]};
    return {1'b0, v[31:0]};
  endfunction

  // Complex sum, difference, product or quotient of one word
  function automatic cplx_res_t cplx_result(input op_e op,
                                            input logic signed [31:0] ar, ai, br, bi);
    logic signed [127:0] xr, xi, yr, yi, re, im, den;
    logic [32:0]         cr, ci;
    cplx_res_t r;
    xr = ar;
    xi = ai;
    yr = br;
    yi = bi;
    r.dz = 1'b0;
    r.ovf = 1'b0;
    case (op)
      OP_ADD: begin
        re = xr + yr;
        im = xi + yi;
      end
      OP_SUB: begin
        re = xr - yr;
        im = xi - yi;
      end
      OP_MUL: begin
        // floor on the exact sum of products
        re = (xr * yr - xi * yi) >>> FRAC;
        im = (xi * yr + yi * xr) >>> FRAC;
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.re = '0;
          r.im = '0;
          r.dz = 1'b1;
          return r;
        end
        // A * conj(B) / |B|^2, truncated toward zero
        re = ((xr * yr + xi * yi) <<< FRAC) / den;
        im = ((xi * yr - yi * xr) <<< FRAC) / den;
      end
    endcase
    cr = clamp_q16(re);
    ci = clamp_q16(im);
    r.re = cr[31:0];
    r.im = ci[31:0];
    r.ovf = cr[32] | ci[32];
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Operand component: full range, edges or modest magnitudes
  function automatic logic signed [31:0] rand_comp();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3, 4: return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
      5: return $signed($urandom_range(0, 32'h0000_1fff)) - 32'sh0000_1000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word and hold it until taken; returns at the falling edge after
  task automatic send_word(input op_e op, input logic signed [31:0] ar, ai, br, bi);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i = op;
    a_re_i = ar;
    a_im_i = ai;
    b_re_i = br;
    b_im_i = bi;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(cplx_result(op, ar, ai, br, bi));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  // Edges of the range through every operation, plus the zero divisor
  task automatic test_directed();
    op_e op;
    steady = 1'b1;
    for (int k = 0; k < 4; k++) begin
      op = op_e'(k);
      send_word(op, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_word(op, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_word(op, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
      send_word(op, 32'sh0001_8000, -32'sh0000_4000, 32'sh0000_8000, 32'sh0002_0000);
      send_word(op, -32'sh1, 32'sh1, 32'sh1, -32'sh1);
    end
    // zero divisor, with and without a zero dividend
    send_word(OP_DIV, 32'sh0001_0000, -32'sh0003_0000, '0, '0);
    send_word(OP_DIV, '0, '0, '0, '0);
    // divide by one, and by the smallest step (quotient overflows)
    send_word(OP_DIV, 32'sh1234_5678, -32'sh0765_4321, 32'sh0001_0000, '0);
    send_word(OP_DIV, 32'sh0001_0000, 32'sh0001_0000, 32'sh1, '0);
    // product of tiny values rounds down to minus one step
    send_word(OP_MUL, -32'sh1, '0, 32'sh1, '0);
    steady = 1'b0;
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 100) steady = ~steady;  // stretches with no idling
      send_word(op_e'($urandom_range(0, 3)), rand_comp(), rand_comp(),
                rand_comp(), rand_comp());
    end
    steady = 1'b0;
  endtask

  // Sender holds off until the pipeline is empty, then resumes
  task automatic test_drain_pause();
    test_random(40);
    wait_drained();
    repeat (5) @(negedge clk_i);
    test_random(40);
  endtask

  // Result stall: random, mostly short, sometimes long, none while steady
  initial begin
    int len;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      len = idle_len();
      if (len > 0) begin
        out_stall_i = 1'b1;
        repeat (len) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Result checker: compare each taken word with the oldest expectation
  always @(posedge clk_i) begin
    cplx_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word re=%h im=%h", $time, res_re_o, res_im_o);
      end else begin
        e = pending_q.pop_front();
        if (res_re_o !== e.re) begin
          errors++;
          $display("%0t: res_re exp %h got %h", $time, e.re, res_re_o);
        end
        if (res_im_o !== e.im) begin
          errors++;
          $display("%0t: res_im exp %h got %h", $time, e.im, res_im_o);
        end
        if (div_by_zero_o !== e.dz) begin
          errors++;
          $display("%0t: div_by_zero exp %b got %b", $time, e.dz, div_by_zero_o);
        end
        if (overflow_o !== e.ovf) begin
          errors++;
          $display("%0t: overflow exp %b got %b", $time, e.ovf, overflow_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    steady = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = OP_ADD;
    a_re_i = '0;
    a_im_i = '0;
    b_re_i = '0;
    b_im_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(500);
    test_drain_pause();
    test_random(550);

    wait_drained();
    repeat (LATENCY + 10) @(negedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/cau_pkg.sv
rtl/core/cau_div_pipe.sv
rtl/core/complex_arithmetic_unit_top.sv
verif/tb_complex_arithmetic_unit_top.sv
